// ===== design/md5sh_pkg.sv =====
// Shared types, constants and round tables of the byte-serial MD5 hasher.
// Used by md5sh_round and md5_stream_hasher_core; depends on nothing.
`default_nettype none

package md5sh_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned BlkAddrW = $clog2(BlkWords);
  localparam int unsigned CountW  = 64;
  localparam int unsigned PosW    = 6;

  localparam logic [WordW-1:0] ChainInit0 = 32'h6745_2301;
  localparam logic [WordW-1:0] ChainInit1 = 32'hefcd_ab89;
  localparam logic [WordW-1:0] ChainInit2 = 32'h98ba_dcfe;
  localparam logic [WordW-1:0] ChainInit3 = 32'h1032_5476;

  localparam logic [7:0] PadByte = 8'h80;

  // Working variables of the compression.
  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } abcd_t;

  function automatic logic [WordW-1:0] round_k(input logic [5:0] i);
    logic [WordW-1:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by round i; all arithmetic is modulo 16.
  function automatic logic [BlkAddrW-1:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] m;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    m = lo;
      2'd1:    m = 4'((lo << 2) + lo + 4'd1);
      2'd2:    m = 4'((lo << 1) + lo + 4'd5);
      default: m = 4'((lo << 3) - lo);
    endcase
    return m;
  endfunction

  function automatic logic [WordW-1:0] swap32(input logic [WordW-1:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

`default_nettype wire

// ===== design/md5_stream_hasher_core.sv =====
// Byte-serial MD5 hasher: top level with control, chaining words and block RAM.
// Depends on md5sh_pkg, md5sh_ram and md5sh_round.
// Absorb bytes are accepted only while idle; the 64th byte of a block starts the compression
// (64 rounds at one per cycle behind the registered RAM read, then the chain update).
// A finalize item runs the padding block, and a second block when the length spills over,
// before the four digest words leave, one per cycle as the sink takes them.
// Synchronous active-low reset loads the initial chain values and clears count and
// position; the block RAM is not cleared. These are restored after the fourth digest word.
`default_nettype none

module md5_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] digest_word, [33:32] word_index
  output logic             out_tlast   // last_word
);

  localparam int unsigned WordW = md5sh_pkg::WordW;
  localparam int unsigned AddrW = md5sh_pkg::BlkAddrW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COMP = 4'b0010,
    ST_FOLD = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    SRC_RAM,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN_LO,
    SRC_LEN_HI
  } src_t;

  state_t                        state_r;
  logic [WordW-1:0]              chain_r [4];
  logic [md5sh_pkg::CountW-1:0]  count_r;
  logic [md5sh_pkg::PosW-1:0]    pos_r;
  logic [WordW-1:0]              acc_r;
  logic [WordW-1:0]              pad_r;
  logic [AddrW-1:0]              fw_r;
  logic                          fin_r;
  logic                          second_r;
  logic                          blk2_r;
  logic [6:0]                    cnt_r;
  logic [5:0]                    ridx_r;
  src_t                          src_r;
  md5sh_pkg::abcd_t              work_r;
  logic [1:0]                    emit_idx_r;

  logic                          in_acc;
  logic                          out_acc;
  logic [1:0]                    lane;
  logic [WordW-1:0]              byte_word;
  logic [WordW-1:0]              pad_word;
  logic                          ram_we;
  logic [AddrW-1:0]              rd_addr;
  logic [WordW-1:0]              ram_rdata;
  src_t                          src_sel;
  logic [WordW-1:0]              msg_word;
  md5sh_pkg::abcd_t              round_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tlast  = (emit_idx_r == 2'd3);
  assign out_tdata  = {6'd0, emit_idx_r, md5sh_pkg::swap32(chain_r[emit_idx_r])};

  assign lane = pos_r[1:0];

  // Merge the incoming byte into the word being assembled, and build the
  // padded word: earlier bytes kept, the pad marker, then zeros.
  always_comb begin
    byte_word = acc_r;
    byte_word[{lane, 3'b000} +: 8] = in_tdata;
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < lane) begin
        pad_word[8*k +: 8] = acc_r[8*k +: 8];
      end else if (2'(k) == lane) begin
        pad_word[8*k +: 8] = md5sh_pkg::PadByte;
      end else begin
        pad_word[8*k +: 8] = 8'h00;
      end
    end
  end

  assign ram_we  = in_acc && !in_tuser[0] && (lane == 2'd3);
  assign rd_addr = md5sh_pkg::msg_index(cnt_r[5:0]);

  md5sh_ram #(
    .WIDTH (WordW),
    .DEPTH (md5sh_pkg::BlkWords)
  ) u_blk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r[5:2]),
    .wdata (byte_word),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Words past the message come from padding logic rather than the RAM.
  always_comb begin
    if (blk2_r) begin
      if (rd_addr == AddrW'(14)) begin
        src_sel = SRC_LEN_LO;
      end else if (rd_addr == AddrW'(15)) begin
        src_sel = SRC_LEN_HI;
      end else begin
        src_sel = SRC_ZERO;
      end
    end else if (!fin_r || rd_addr < fw_r) begin
      src_sel = SRC_RAM;
    end else if (rd_addr == fw_r) begin
      src_sel = SRC_PAD;
    end else if (!second_r && rd_addr == AddrW'(14)) begin
      src_sel = SRC_LEN_LO;
    end else if (!second_r && rd_addr == AddrW'(15)) begin
      src_sel = SRC_LEN_HI;
    end else begin
      src_sel = SRC_ZERO;
    end
  end

  always_comb begin
    case (src_r)
      SRC_RAM:    msg_word = ram_rdata;
      SRC_PAD:    msg_word = pad_r;
      SRC_LEN_LO: msg_word = count_r[WordW-1:0];
      SRC_LEN_HI: msg_word = count_r[2*WordW-1:WordW];
      default:    msg_word = '0;
    endcase
  end

  md5sh_round u_round (
    .cur      (work_r),
    .msg_word (msg_word),
    .idx      (ridx_r),
    .nxt      (round_nxt)
  );

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_r  <= byte_word;
      pad_r  <= pad_word;
      fw_r   <= pos_r[5:2];
    end
    ridx_r <= cnt_r[5:0];
    src_r  <= src_sel;
    if (state_r == ST_COMP) begin
      if (cnt_r == 7'd0) begin
        work_r <= '{a: chain_r[0], b: chain_r[1], c: chain_r[2], d: chain_r[3]};
      end else begin
        work_r <= round_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      chain_r[0] <= md5sh_pkg::ChainInit0;
      chain_r[1] <= md5sh_pkg::ChainInit1;
      chain_r[2] <= md5sh_pkg::ChainInit2;
      chain_r[3] <= md5sh_pkg::ChainInit3;
      count_r    <= '0;
      pos_r      <= '0;
      fin_r      <= 1'b0;
      second_r   <= 1'b0;
      blk2_r     <= 1'b0;
      cnt_r      <= '0;
      emit_idx_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_r  <= '0;
            blk2_r <= 1'b0;
            if (in_tuser[0]) begin
              fin_r    <= 1'b1;
              second_r <= (pos_r[5:3] == 3'd7);
              state_r  <= ST_COMP;
            end else begin
              fin_r   <= 1'b0;
              count_r <= count_r + md5sh_pkg::CountW'(8);
              pos_r   <= pos_r + 1'b1;
              if (pos_r == '1) begin
                state_r <= ST_COMP;
              end
            end
          end
        end
        ST_COMP: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'd64) begin
            state_r <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          chain_r[0] <= chain_r[0] + work_r.a;
          chain_r[1] <= chain_r[1] + work_r.b;
          chain_r[2] <= chain_r[2] + work_r.c;
          chain_r[3] <= chain_r[3] + work_r.d;
          cnt_r      <= '0;
          if (fin_r && second_r && !blk2_r) begin
            blk2_r  <= 1'b1;
            state_r <= ST_COMP;
          end else if (fin_r) begin
            emit_idx_r <= '0;
            state_r    <= ST_EMIT;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            emit_idx_r <= emit_idx_r + 1'b1;
            if (emit_idx_r == 2'd3) begin
              chain_r[0] <= md5sh_pkg::ChainInit0;
              chain_r[1] <= md5sh_pkg::ChainInit1;
              chain_r[2] <= md5sh_pkg::ChainInit2;
              chain_r[3] <= md5sh_pkg::ChainInit3;
              count_r    <= '0;
              pos_r      <= '0;
              fin_r      <= 1'b0;
              second_r   <= 1'b0;
              blk2_r     <= 1'b0;
              state_r    <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/md5sh_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the message block of the MD5 hasher; no dependencies.
`default_nettype none

module md5sh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/md5sh_round.sv =====
// One MD5 round step: boolean function, additions and rotation.
// Depends on md5sh_pkg for the round constant and rotation tables.
`default_nettype none

module md5sh_round (
  input  wire md5sh_pkg::abcd_t           cur,
  input  wire logic [md5sh_pkg::WordW-1:0] msg_word,
  input  wire logic [5:0]                  idx,
  output md5sh_pkg::abcd_t                 nxt
);

  logic [md5sh_pkg::WordW-1:0]   f;
  logic [md5sh_pkg::WordW-1:0]   sum;
  logic [2*md5sh_pkg::WordW-1:0] dbl;
  logic [md5sh_pkg::WordW-1:0]   rot;

  always_comb begin
    case (idx[5:4])
      2'd0:    f = cur.d ^ (cur.b & (cur.c ^ cur.d));
      2'd1:    f = cur.c ^ (cur.d & (cur.b ^ cur.c));
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
    sum = cur.a + f + md5sh_pkg::round_k(idx) + msg_word;
    // Rotate left by shifting a doubled copy and keeping the upper half.
    dbl = {sum, sum} << md5sh_pkg::rot_amt(idx);
    rot = dbl[2*md5sh_pkg::WordW-1 -: md5sh_pkg::WordW];
    nxt.a = cur.d;
    nxt.b = cur.b + rot;
    nxt.c = cur.b;
    nxt.d = cur.c;
  end

endmodule

`default_nettype wire
